// ===== rtl/kvzs_pkg.sv =====
// Package of types and constants shared by the key/velocity zone selector.
package kvzs_pkg;

	localparam int unsigned MAX_ZONES_DEF = 64;

	localparam logic [2:0] ADDR_ZONE_COUNT = 3'd0;

	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_LOOKUP = 1'b1;

	localparam logic [2:0] KIND_NONE    = 3'd0;
	localparam logic [2:0] KIND_KEY_VEL = 3'd1;
	localparam logic [2:0] KIND_KEY     = 3'd2;
	localparam logic [2:0] KIND_NEAR_VEL = 3'd3;
	localparam logic [2:0] KIND_NEAR    = 3'd4;

	typedef struct packed {
		logic       mode;
		logic [5:0] zone_index;
		logic [6:0] zone_low_key;
		logic [6:0] zone_high_key;
		logic [6:0] zone_low_vel;
		logic [6:0] zone_high_vel;
		logic [6:0] zone_root;
		logic [6:0] note;
		logic [6:0] velocity;
	} req_word_t;

	typedef struct packed {
		logic       found;
		logic [5:0] zone_sel;
		logic [2:0] match_kind;
	} rsp_word_t;

	typedef struct packed {
		logic [6:0] low_key;
		logic [6:0] high_key;
		logic [6:0] low_vel;
		logic [6:0] high_vel;
		logic [6:0] root;
	} zone_entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

endpackage

// ===== rtl/key_velocity_zone_selector.sv =====
// Key/velocity zone selector: a zone table in one memory and a scan over it per lookup.
//
// A write word (mode 0) stores one zone entry. A lookup word (mode 1) occupies the
// block through these steps, with zone_count clipped to MAX_ZONES: it is accepted,
// each table entry is read in turn through the single read port of the zone
// memory, the read stage drains and the result is formed. An empty table skips the
// scan and the drain. The result step waits for as long as the output register
// still holds an earlier result that the response side stalls. The input is stalled
// while a lookup runs; the result sits in an output register, so a finished result
// may wait while the next word is taken. The table needs no clearing pass: an entry
// below zone_count must have been written before it is looked up.
// Configuration is written through the APB port at byte address 0 (zone_count).
module key_velocity_zone_selector #(
	parameter int unsigned MAX_ZONES = kvzs_pkg::MAX_ZONES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 req_valid,
	output logic                 req_stall,
	input  kvzs_pkg::req_word_t  req,
	// response channel
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output kvzs_pkg::rsp_word_t  rsp,
	// configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int unsigned IDX_W = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
	localparam int unsigned LIM_W = $clog2(MAX_ZONES + 1);

	kvzs_pkg::state_t state_q, state_d;

	// configuration
	logic [6:0] zone_count_q;
	logic       cfg_we;

	// table memory
	kvzs_pkg::zone_entry_t mem [MAX_ZONES];
	kvzs_pkg::zone_entry_t rd_data_s1;
	logic                  rd_v_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic                  mem_we, mem_re;
	logic [IDX_W-1:0]      wr_addr;
	logic [31:0]           wr_idx_ext;

	// scan control
	logic [LIM_W-1:0] limit_q, limit_c;
	logic [LIM_W-1:0] scan_q;
	logic             scan_last;
	logic [6:0]       note_q, vel_q;

	// candidate trackers, one per priority class
	logic             have_kv_q, have_k_q, have_nv_q, have_n_q;
	logic [IDX_W-1:0] idx_kv_q, idx_k_q, idx_nv_q, idx_n_q;
	logic [6:0]       dist_nv_q, dist_n_q;

	logic       key_ok, vel_ok;
	logic [6:0] root_gap;

	// handshake
	logic                req_acc, start_lookup, rsp_free, load_rsp;
	logic                rsp_valid_q;
	kvzs_pkg::rsp_word_t rsp_q, rsp_c;
	logic [IDX_W-1:0]    sel_idx;
	logic [31:0]         sel_ext;

	assign req_acc      = req_valid && !req_stall;
	assign start_lookup = req_acc && (req.mode == kvzs_pkg::MODE_LOOKUP);
	assign rsp_free     = !rsp_valid_q || !rsp_stall;

	// ---------------------------------------------------------------- APB
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr == kvzs_pkg::ADDR_ZONE_COUNT);
	assign prdata = (paddr == kvzs_pkg::ADDR_ZONE_COUNT) ? {25'd0, zone_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_count_q <= 7'd0;
		end else if (cfg_we) begin
			zone_count_q <= pwdata[6:0];
		end
	end

	// Clip the zone count to the table depth.
	always_comb begin
		if (32'(zone_count_q) > MAX_ZONES) begin
			limit_c = LIM_W'(MAX_ZONES);
		end else begin
			limit_c = LIM_W'(zone_count_q);
		end
	end

	// ---------------------------------------------------------------- state machine
	assign scan_last = (LIM_W'(scan_q + 1'b1) == limit_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kvzs_pkg::ST_IDLE: begin
				if (start_lookup) begin
					state_d = (limit_c == '0) ? kvzs_pkg::ST_FINISH : kvzs_pkg::ST_SCAN;
				end
			end
			kvzs_pkg::ST_SCAN: begin
				if (scan_last) begin
					state_d = kvzs_pkg::ST_DRAIN;
				end
			end
			kvzs_pkg::ST_DRAIN: begin
				state_d = kvzs_pkg::ST_FINISH;
			end
			kvzs_pkg::ST_FINISH: begin
				if (rsp_free) begin
					state_d = kvzs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = kvzs_pkg::ST_IDLE;
			end
		endcase
	end

	// Writes land only while idle and every read comes later in a scan, so
	// the same entry is never written and read in one cycle.
	always_comb begin
		req_stall = 1'b1;
		mem_re    = 1'b0;
		load_rsp  = 1'b0;
		unique case (state_q)
			kvzs_pkg::ST_IDLE:   req_stall = 1'b0;
			kvzs_pkg::ST_SCAN:   mem_re    = 1'b1;
			kvzs_pkg::ST_DRAIN:  ;
			kvzs_pkg::ST_FINISH: load_rsp  = rsp_free;
			default:             ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kvzs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------------------------------------------------------- zone memory
	// Drop writes aimed past the table depth.
	assign wr_idx_ext = 32'(req.zone_index);
	assign wr_addr    = wr_idx_ext[IDX_W-1:0];
	assign mem_we     = req_acc && (req.mode == kvzs_pkg::MODE_WRITE) && (wr_idx_ext < MAX_ZONES);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= '{low_key:  req.zone_low_key,
			                  high_key: req.zone_high_key,
			                  low_vel:  req.zone_low_vel,
			                  high_vel: req.zone_high_vel,
			                  root:     req.zone_root};
		end
		if (mem_re) begin
			rd_data_s1 <= mem[scan_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
			scan_q  <= '0;
		end else begin
			rd_v_s1 <= mem_re;
			// Restart the scan at entry zero on each lookup, advance per read.
			if (start_lookup) begin
				scan_q <= '0;
			end else if (mem_re) begin
				scan_q <= LIM_W'(scan_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_q[IDX_W-1:0];
		if (start_lookup) begin
			note_q  <= req.note;
			vel_q   <= req.velocity;
			limit_q <= limit_c;
		end
	end

	// ---------------------------------------------------------------- match tracking
	assign key_ok   = (note_q >= rd_data_s1.low_key) && (note_q <= rd_data_s1.high_key);
	assign vel_ok   = (vel_q >= rd_data_s1.low_vel) && (vel_q <= rd_data_s1.high_vel);
	assign root_gap = (note_q >= rd_data_s1.root) ? (note_q - rd_data_s1.root)
	                                              : (rd_data_s1.root - note_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_kv_q <= 1'b0;
			have_k_q  <= 1'b0;
			have_nv_q <= 1'b0;
			have_n_q  <= 1'b0;
		end else if (start_lookup) begin
			have_kv_q <= 1'b0;
			have_k_q  <= 1'b0;
			have_nv_q <= 1'b0;
			have_n_q  <= 1'b0;
		end else if (rd_v_s1) begin
			if (key_ok && vel_ok) have_kv_q <= 1'b1;
			if (key_ok)           have_k_q  <= 1'b1;
			if (vel_ok)           have_nv_q <= 1'b1;
			have_n_q <= 1'b1;
		end
	end

	// First hit wins for the range classes; a strictly smaller distance wins
	// for the nearest-root classes, so ties keep the lower index.
	always_ff @(posedge clk) begin
		if (rd_v_s1) begin
			if (key_ok && vel_ok && !have_kv_q) idx_kv_q <= idx_s1;
			if (key_ok && !have_k_q)            idx_k_q  <= idx_s1;
			if (vel_ok && (!have_nv_q || root_gap < dist_nv_q)) begin
				idx_nv_q  <= idx_s1;
				dist_nv_q <= root_gap;
			end
			if (!have_n_q || root_gap < dist_n_q) begin
				idx_n_q  <= idx_s1;
				dist_n_q <= root_gap;
			end
		end
	end

	// ---------------------------------------------------------------- result
	always_comb begin
		sel_idx          = '0;
		rsp_c.match_kind = kvzs_pkg::KIND_NONE;
		if (have_kv_q) begin
			sel_idx          = idx_kv_q;
			rsp_c.match_kind = kvzs_pkg::KIND_KEY_VEL;
		end else if (have_k_q) begin
			sel_idx          = idx_k_q;
			rsp_c.match_kind = kvzs_pkg::KIND_KEY;
		end else if (have_nv_q) begin
			sel_idx          = idx_nv_q;
			rsp_c.match_kind = kvzs_pkg::KIND_NEAR_VEL;
		end else if (have_n_q) begin
			sel_idx          = idx_n_q;
			rsp_c.match_kind = kvzs_pkg::KIND_NEAR;
		end
		sel_ext        = 32'(sel_idx);
		rsp_c.zone_sel = sel_ext[5:0];
		rsp_c.found    = (rsp_c.match_kind != kvzs_pkg::KIND_NONE);
	end

	// Hold the result until the response side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q <= rsp_c;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ---------------------------------------------------------------- assertions
	a_found_kind : assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.found == (rsp.match_kind != kvzs_pkg::KIND_NONE)))
		else $error("found disagrees with match_kind");

	a_none_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.found) |-> (rsp.zone_sel == 6'd0))
		else $error("zone_sel nonzero with no zone found");

	a_read_stage : assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> ($past(state_q) == kvzs_pkg::ST_SCAN))
		else $error("read stage valid outside a scan");

	a_scan_bound : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == kvzs_pkg::ST_SCAN) |-> (scan_q < limit_q))
		else $error("scan address beyond zone count");

endmodule
